>>> src/tisp_pkg.sv
// ----------------------------------------------------------------------------
// Terminal input sequence parser package
// Shared types, event codes and the special key uniform form table.
// ----------------------------------------------------------------------------
`default_nettype none

package tisp_pkg;

    localparam logic [7:0] C_ESC = 8'h1B;
    localparam logic [7:0] C_BSL = 8'h5C;
    localparam logic [7:0] C_NUL = 8'h00;

    localparam logic [2:0] KIND_CHAR    = 3'd0;
    localparam logic [2:0] KIND_SPECIAL = 3'd1;
    localparam logic [2:0] KIND_MOUSE   = 3'd2;
    localparam logic [2:0] KIND_CURSOR  = 3'd3;
    localparam logic [2:0] KIND_SHAPE   = 3'd4;

    localparam int REMAP_COUNT = 35;

    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  btn;
        logic [1:0]  motion;
        logic        shift;
        logic        meta;
        logic        ctrl;
        logic [15:0] x;
        logic [15:0] y;
        logic [8:0]  shape;
        logic [6:0]  len;
        logic        remap;
        logic [5:0]  ridx;
    } ev_desc_t;

    typedef struct packed {
        logic [2:0]  flen;
        logic [39:0] from;
        logic [2:0]  tlen;
        logic [39:0] to;
    } remap_t;

    function automatic logic [39:0] pk(input logic [7:0] c0, input logic [7:0] c1,
                                       input logic [7:0] c2, input logic [7:0] c3,
                                       input logic [7:0] c4);
        return {c4, c3, c2, c1, c0};
    endfunction

    function automatic remap_t remap_entry(input logic [5:0] idx);
        remap_t e;
        e = '0;
        case (idx)
            6'd0:  e = '{3'd1, pk(8'h0D, C_NUL, C_NUL, C_NUL, C_NUL),
                         3'd1, pk(8'h0A, C_NUL, C_NUL, C_NUL, C_NUL)};
            6'd1:  e = '{3'd1, pk(8'h08, C_NUL, C_NUL, C_NUL, C_NUL),
                         3'd1, pk(8'h7F, C_NUL, C_NUL, C_NUL, C_NUL)};
            6'd2:  e = '{3'd3, pk(C_ESC, "O", "A", C_NUL, C_NUL),
                         3'd3, pk(C_ESC, "[", "A", C_NUL, C_NUL)};
            6'd3:  e = '{3'd3, pk(C_ESC, "O", "B", C_NUL, C_NUL),
                         3'd3, pk(C_ESC, "[", "B", C_NUL, C_NUL)};
            6'd4:  e = '{3'd3, pk(C_ESC, "O", "C", C_NUL, C_NUL),
                         3'd3, pk(C_ESC, "[", "C", C_NUL, C_NUL)};
            6'd5:  e = '{3'd3, pk(C_ESC, "O", "D", C_NUL, C_NUL),
                         3'd3, pk(C_ESC, "[", "D", C_NUL, C_NUL)};
            6'd6:  e = '{3'd3, pk(C_ESC, "O", "H", C_NUL, C_NUL),
                         3'd3, pk(C_ESC, "[", "H", C_NUL, C_NUL)};
            6'd7:  e = '{3'd3, pk(C_ESC, "O", "F", C_NUL, C_NUL),
                         3'd3, pk(C_ESC, "[", "F", C_NUL, C_NUL)};
            6'd8:  e = '{3'd4, pk(C_ESC, "[", "[", "A", C_NUL),
                         3'd3, pk(C_ESC, "O", "P", C_NUL, C_NUL)};
            6'd9:  e = '{3'd4, pk(C_ESC, "[", "[", "B", C_NUL),
                         3'd3, pk(C_ESC, "O", "Q", C_NUL, C_NUL)};
            6'd10: e = '{3'd4, pk(C_ESC, "[", "[", "C", C_NUL),
                         3'd3, pk(C_ESC, "O", "R", C_NUL, C_NUL)};
            6'd11: e = '{3'd4, pk(C_ESC, "[", "[", "D", C_NUL),
                         3'd3, pk(C_ESC, "O", "S", C_NUL, C_NUL)};
            6'd12: e = '{3'd4, pk(C_ESC, "[", "[", "E", C_NUL),
                         3'd5, pk(C_ESC, "[", "1", "5", "~")};
            6'd13: e = '{3'd5, pk(C_ESC, "[", "1", "1", "~"),
                         3'd3, pk(C_ESC, "O", "P", C_NUL, C_NUL)};
            6'd14: e = '{3'd5, pk(C_ESC, "[", "1", "2", "~"),
                         3'd3, pk(C_ESC, "O", "Q", C_NUL, C_NUL)};
            6'd15: e = '{3'd5, pk(C_ESC, "[", "1", "3", "~"),
                         3'd3, pk(C_ESC, "O", "R", C_NUL, C_NUL)};
            6'd16: e = '{3'd5, pk(C_ESC, "[", "1", "4", "~"),
                         3'd3, pk(C_ESC, "O", "S", C_NUL, C_NUL)};
            6'd17: e = '{3'd3, pk(C_ESC, "O", "t", C_NUL, C_NUL),
                         3'd5, pk(C_ESC, "[", "1", "5", "~")};
            6'd18: e = '{3'd3, pk(C_ESC, "O", "u", C_NUL, C_NUL),
                         3'd5, pk(C_ESC, "[", "1", "7", "~")};
            6'd19: e = '{3'd3, pk(C_ESC, "O", "v", C_NUL, C_NUL),
                         3'd5, pk(C_ESC, "[", "1", "8", "~")};
            6'd20: e = '{3'd3, pk(C_ESC, "O", "l", C_NUL, C_NUL),
                         3'd5, pk(C_ESC, "[", "1", "9", "~")};
            6'd21: e = '{3'd3, pk(C_ESC, "O", "w", C_NUL, C_NUL),
                         3'd5, pk(C_ESC, "[", "2", "0", "~")};
            6'd22: e = '{3'd3, pk(C_ESC, "O", "x", C_NUL, C_NUL),
                         3'd5, pk(C_ESC, "[", "2", "1", "~")};
            6'd23: e = '{3'd3, pk(C_ESC, "[", "M", C_NUL, C_NUL),
                         3'd3, pk(C_ESC, "O", "P", C_NUL, C_NUL)};
            6'd24: e = '{3'd3, pk(C_ESC, "[", "N", C_NUL, C_NUL),
                         3'd3, pk(C_ESC, "O", "Q", C_NUL, C_NUL)};
            6'd25: e = '{3'd3, pk(C_ESC, "[", "O", C_NUL, C_NUL),
                         3'd3, pk(C_ESC, "O", "R", C_NUL, C_NUL)};
            6'd26: e = '{3'd3, pk(C_ESC, "[", "P", C_NUL, C_NUL),
                         3'd3, pk(C_ESC, "O", "S", C_NUL, C_NUL)};
            6'd27: e = '{3'd3, pk(C_ESC, "[", "Q", C_NUL, C_NUL),
                         3'd5, pk(C_ESC, "[", "1", "5", "~")};
            6'd28: e = '{3'd3, pk(C_ESC, "[", "R", C_NUL, C_NUL),
                         3'd5, pk(C_ESC, "[", "1", "7", "~")};
            6'd29: e = '{3'd3, pk(C_ESC, "[", "S", C_NUL, C_NUL),
                         3'd5, pk(C_ESC, "[", "1", "8", "~")};
            6'd30: e = '{3'd3, pk(C_ESC, "[", "T", C_NUL, C_NUL),
                         3'd5, pk(C_ESC, "[", "1", "9", "~")};
            6'd31: e = '{3'd3, pk(C_ESC, "[", "U", C_NUL, C_NUL),
                         3'd5, pk(C_ESC, "[", "2", "0", "~")};
            6'd32: e = '{3'd3, pk(C_ESC, "[", "V", C_NUL, C_NUL),
                         3'd5, pk(C_ESC, "[", "2", "1", "~")};
            6'd33: e = '{3'd3, pk(C_ESC, "[", "W", C_NUL, C_NUL),
                         3'd5, pk(C_ESC, "[", "2", "3", "~")};
            6'd34: e = '{3'd3, pk(C_ESC, "[", "X", C_NUL, C_NUL),
                         3'd5, pk(C_ESC, "[", "2", "4", "~")};
            default: e = '0;
        endcase
        return e;
    endfunction

endpackage

`default_nettype wire

>>> src/tisp_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tisp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

`default_nettype wire

>>> src/tisp_front.sv
// ----------------------------------------------------------------------------
// Parser front end
// Accepts bytes and ticks, stores the sequence and classifies it into events.
// ----------------------------------------------------------------------------
`default_nettype none

module tisp_front #(
    parameter int SEQ_LIMIT = 64
) (
    input  wire logic                         clk,
    input  wire logic                         rstn,
    input  wire logic                         cfg_we,
    input  wire logic [15:0]                  cfg_data,
    input  wire logic                         in_fire,
    input  wire logic                         func,
    input  wire logic [7:0]                   data_byte,
    input  wire logic [15:0]                  elapsed,
    output logic                              ram_we,
    output logic [$clog2(SEQ_LIMIT)-1:0]      ram_waddr,
    output logic [7:0]                        ram_wdata,
    output logic                              ev_push,
    output tisp_pkg::ev_desc_t                ev
);
    import tisp_pkg::*;

    localparam logic [3:0] PH_IDLE = 4'd0;
    localparam logic [3:0] PH_UTF  = 4'd1;
    localparam logic [3:0] PH_ESC1 = 4'd2;
    localparam logic [3:0] PH_ESC2 = 4'd3;
    localparam logic [3:0] PH_STR  = 4'd4;
    localparam logic [3:0] PH_CSI  = 4'd5;

    logic [15:0] thr_reg, thr_next;
    logic [6:0]  len_reg, len_next;
    logic [15:0] idle_reg, idle_next;
    logic [3:0]  ph_reg, ph_next;
    logic [2:0]  rem_reg, rem_next;
    logic [2:0]  ones_reg, ones_next;
    logic [20:0] code_reg, code_next;
    logic        esc_reg, esc_next;
    logic        dcs_reg, dcs_next;
    logic        shok_reg, shok_next;
    logic [7:0]  shb_reg, shb_next;
    logic [15:0] acc_reg, acc_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [15:0] arg_reg [3];
    logic [15:0] arg_next [3];
    logic [7:0]  hb_reg [5];
    logic [7:0]  hb_next [5];

    always_comb begin
        logic [6:0]  nlen;
        logic [6:0]  mlen;
        logic [7:0]  b;
        logic [2:0]  ones;
        logic [20:0] cp;
        logic [19:0] prod;
        logic [16:0] sum;
        logic [15:0] pa [3];
        logic [2:0]  pcnt;
        logic        fin;
        logic        drop;
        logic [2:0]  kind;
        logic        hit;
        logic        eq;
        logic [5:0]  hidx;
        remap_t      re;
        logic [7:0]  mhb [5];

        thr_next  = cfg_we ? cfg_data : thr_reg;
        len_next  = len_reg;
        idle_next = idle_reg;
        ph_next   = ph_reg;
        rem_next  = rem_reg;
        ones_next = ones_reg;
        code_next = code_reg;
        esc_next  = esc_reg;
        dcs_next  = dcs_reg;
        shok_next = shok_reg;
        shb_next  = shb_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        arg_next  = arg_reg;
        hb_next   = hb_reg;
        b    = data_byte;
        nlen = len_reg + 7'd1;
        fin  = 1'b0;
        drop = 1'b0;
        kind = KIND_SPECIAL;
        ev   = '0;
        ram_we    = in_fire && !func;
        ram_waddr = len_reg[$clog2(SEQ_LIMIT)-1:0];
        ram_wdata = b;
        ones = 3'd0;
        casez (b)
            8'b0???????: ones = 3'd0;
            8'b10??????: ones = 3'd1;
            8'b110?????: ones = 3'd2;
            8'b1110????: ones = 3'd3;
            8'b11110???: ones = 3'd4;
            default:     ones = 3'd5;
        endcase
        cp   = {code_reg[14:0], b[5:0]};
        prod = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0} + {16'd0, b[3:0]};
        pa   = arg_reg;
        if (cnt_reg < 3'd3) begin
            pa[cnt_reg[1:0]] = acc_reg;
        end
        pcnt = (cnt_reg < 3'd7) ? cnt_reg + 3'd1 : cnt_reg;
        sum  = {1'b0, idle_reg} + {1'b0, elapsed};

        for (int i = 0; i < 5; i++) begin
            hb_next[i] = (!func && len_reg == 7'(i)) ? b : hb_reg[i];
        end

        if (in_fire && func) begin
            idle_next = sum[16] ? 16'hFFFF : sum[15:0];
            if (idle_next >= thr_reg) begin
                idle_next = 16'd0;
                if (len_reg != 7'd0) begin
                    fin = 1'b1;
                    kind = KIND_SPECIAL;
                end
            end
        end else if (in_fire) begin
            idle_next = 16'd0;
            case (ph_reg)
                PH_IDLE: begin
                    if (b == C_ESC) begin
                        ph_next = PH_ESC1;
                    end else if (b < 8'd32 || b == 8'd127) begin
                        fin = 1'b1;
                        kind = KIND_SPECIAL;
                    end else if (ones == 3'd0) begin
                        fin = 1'b1;
                        kind = KIND_CHAR;
                    end else if (ones == 3'd1 || ones == 3'd5) begin
                        drop = 1'b1;
                    end else begin
                        ph_next   = PH_UTF;
                        ones_next = ones;
                        rem_next  = ones - 3'd1;
                        code_next = 21'({1'b0, b[6:0]} & (8'h7F >> ones));
                    end
                end
                PH_UTF: begin
                    if (b[7:6] != 2'b10) begin
                        drop = 1'b1;
                    end else begin
                        code_next = cp;
                        rem_next  = rem_reg - 3'd1;
                        if (rem_reg == 3'd1) begin
                            if ((ones_reg == 3'd2 && cp >= 21'h80 && cp <= 21'h7FF) ||
                                (ones_reg == 3'd3 && cp >= 21'h800 && cp <= 21'hFFFF) ||
                                (ones_reg == 3'd4 && cp >= 21'h10000 &&
                                 cp <= 21'h10FFFF)) begin
                                fin = 1'b1;
                                kind = KIND_CHAR;
                            end else begin
                                drop = 1'b1;
                            end
                        end
                    end
                end
                PH_ESC1: begin
                    esc_next  = 1'b0;
                    shok_next = 1'b1;
                    acc_next  = 16'd0;
                    cnt_next  = 3'd0;
                    case (b)
                        "P": begin
                            ph_next  = PH_STR;
                            dcs_next = 1'b1;
                        end
                        "]": begin
                            ph_next  = PH_STR;
                            dcs_next = 1'b0;
                        end
                        "[": ph_next = PH_CSI;
                        " ", "#", "%", "(", ")", "*", "+", "O", "N": ph_next = PH_ESC2;
                        default: begin
                            fin = 1'b1;
                            kind = KIND_SPECIAL;
                        end
                    endcase
                end
                PH_ESC2: begin
                    fin = 1'b1;
                    kind = KIND_SPECIAL;
                end
                PH_STR: begin
                    if ((len_reg == 7'd2 && b != "1") || (len_reg == 7'd3 && b != "$") ||
                        (len_reg == 7'd4 && b != "r")) begin
                        shok_next = 1'b0;
                    end
                    if (len_reg == 7'd5) begin
                        shb_next = b;
                    end
                    if (esc_reg) begin
                        esc_next = 1'b0;
                        if (b == C_BSL) begin
                            fin = 1'b1;
                            kind = (dcs_reg && nlen == 7'd10 && shok_reg) ?
                                   KIND_SHAPE : KIND_SPECIAL;
                        end
                    end else if (b == C_ESC) begin
                        esc_next = 1'b1;
                    end
                end
                PH_CSI: begin
                    if (b >= "0" && b <= "9") begin
                        acc_next = (prod > 20'd65535) ? 16'hFFFF : prod[15:0];
                    end else if (b == ";") begin
                        arg_next = pa;
                        cnt_next = pcnt;
                        acc_next = 16'd0;
                    end else if (b >= "@" && b <= "~" && b != "[") begin
                        arg_next = pa;
                        cnt_next = pcnt;
                        acc_next = 16'd0;
                        fin = 1'b1;
                        kind = KIND_SPECIAL;
                        if ((b == "M" || b == "m") && pcnt == 3'd3) begin
                            kind = KIND_MOUSE;
                        end else if (b == "R" && pcnt == 3'd2) begin
                            kind = KIND_CURSOR;
                        end
                    end else if (b == C_ESC) begin
                        fin = 1'b1;
                        kind = KIND_SPECIAL;
                    end
                end
                default: drop = 1'b1;
            endcase
            if (fin || drop) begin
                len_next = 7'd0;
                ph_next  = PH_IDLE;
            end else if (nlen >= 7'(SEQ_LIMIT)) begin
                len_next = 7'd0;
                ph_next  = PH_IDLE;
            end else begin
                len_next = nlen;
            end
        end

        mlen = func ? len_reg : nlen;
        mhb  = func ? hb_reg : hb_next;
        hit  = 1'b0;
        hidx = 6'd0;
        for (int i = 0; i < REMAP_COUNT; i++) begin
            re = remap_entry(6'(i));
            eq = ({4'd0, re.flen} == mlen);
            for (int j = 0; j < 5; j++) begin
                if (3'(j) < re.flen && mhb[j] != re.from[8*j +: 8]) begin
                    eq = 1'b0;
                end
            end
            if (eq) begin
                hit  = 1'b1;
                hidx = 6'(i);
            end
        end

        ev_push = fin;
        ev.kind = kind;
        ev.len  = mlen;
        if (fin && func) begin
            len_next = 7'd0;
            ph_next  = PH_IDLE;
        end
        case (kind)
            KIND_SPECIAL: begin
                re = remap_entry(hidx);
                ev.remap = hit;
                ev.ridx  = hidx;
                if (hit) begin
                    ev.len = {4'd0, re.tlen};
                end
            end
            KIND_MOUSE: begin
                ev.btn    = {pa[0][6], pa[0][1:0]};
                ev.motion = pa[0][5] ? 2'd2 : ((b == "M") ? 2'd1 : 2'd0);
                ev.shift  = pa[0][2];
                ev.meta   = pa[0][3];
                ev.ctrl   = pa[0][4];
                ev.x      = pa[1];
                ev.y      = pa[2];
            end
            KIND_CURSOR: begin
                ev.y = pa[0];
                ev.x = pa[1];
            end
            KIND_SHAPE: ev.shape = {1'b0, shb_reg} - 9'd48;
            default: ev.remap = 1'b0;
        endcase
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            thr_reg  <= 16'd50;
            len_reg  <= 7'd0;
            idle_reg <= 16'd0;
            ph_reg   <= PH_IDLE;
            rem_reg  <= 3'd0;
            ones_reg <= 3'd0;
            code_reg <= 21'd0;
            esc_reg  <= 1'b0;
            dcs_reg  <= 1'b0;
            shok_reg <= 1'b0;
            acc_reg  <= 16'd0;
            cnt_reg  <= 3'd0;
        end else begin
            thr_reg  <= thr_next;
            len_reg  <= len_next;
            idle_reg <= idle_next;
            ph_reg   <= ph_next;
            rem_reg  <= rem_next;
            ones_reg <= ones_next;
            code_reg <= code_next;
            esc_reg  <= esc_next;
            dcs_reg  <= dcs_next;
            shok_reg <= shok_next;
            acc_reg  <= acc_next;
            cnt_reg  <= cnt_next;
        end
        shb_reg <= shb_next;
        arg_reg <= arg_next;
        hb_reg  <= hb_next;
    end
endmodule

`default_nettype wire

>>> src/tisp_back.sv
// ----------------------------------------------------------------------------
// Parser back end
// Replays the bytes of a queued event from the buffer or the uniform table.
// ----------------------------------------------------------------------------
`default_nettype none

module tisp_back #(
    parameter int SEQ_LIMIT = 64
) (
    input  wire logic                         clk,
    input  wire logic                         rstn,
    input  wire logic                         q_valid,
    input  wire tisp_pkg::ev_desc_t           q_data,
    output logic                              q_pop,
    output logic                              idle,
    output logic [$clog2(SEQ_LIMIT)-1:0]      ram_raddr,
    input  wire logic [7:0]                   ram_rdata,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [63:0]                       m_tdata,
    output logic                              m_tlast,
    output logic [7:0]                        m_tuser
);
    import tisp_pkg::*;

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_READ = 2'd1;
    localparam logic [1:0] B_LOAD = 2'd2;
    localparam logic [1:0] B_OUT  = 2'd3;

    logic [1:0] st_reg, st_next;
    logic [6:0] k_reg, k_next;
    ev_desc_t   d_reg, d_next;
    logic [7:0] byte_reg, byte_next;
    logic       last_reg, last_next;
    remap_t     re;

    always_comb begin
        st_next   = st_reg;
        k_next    = k_reg;
        d_next    = d_reg;
        byte_next = byte_reg;
        last_next = last_reg;
        q_pop     = 1'b0;
        re        = remap_entry(d_reg.ridx);
        case (st_reg)
            B_IDLE: begin
                if (q_valid) begin
                    q_pop   = 1'b1;
                    d_next  = q_data;
                    k_next  = 7'd0;
                    st_next = B_READ;
                end
            end
            B_READ: st_next = B_LOAD;
            B_LOAD: begin
                byte_next = d_reg.remap ? re.to[8*k_reg[2:0] +: 8] : ram_rdata;
                last_next = (k_reg == d_reg.len - 7'd1);
                st_next   = B_OUT;
            end
            B_OUT: begin
                if (m_tready) begin
                    if (last_reg) begin
                        st_next = B_IDLE;
                    end else begin
                        k_next  = k_reg + 7'd1;
                        st_next = B_READ;
                    end
                end
            end
            default: st_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            st_reg <= B_IDLE;
        end else begin
            st_reg <= st_next;
        end
        k_reg    <= k_next;
        d_reg    <= d_next;
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    assign idle      = (st_reg == B_IDLE);
    assign ram_raddr = k_reg[$clog2(SEQ_LIMIT)-1:0];
    assign m_tvalid  = (st_reg == B_OUT);
    assign m_tlast   = last_reg;
    assign m_tuser   = {5'd0, d_reg.kind};
    assign m_tdata   = {7'd0, d_reg.shape, d_reg.y, d_reg.x, d_reg.ctrl, d_reg.meta,
                        d_reg.shift, d_reg.motion, d_reg.btn, byte_reg};
endmodule

`default_nettype wire

>>> src/terminal_input_sequence_parser_core.sv
// ----------------------------------------------------------------------------
// Terminal input sequence parser
// Groups terminal input bytes into character, key, mouse and report events.
// ----------------------------------------------------------------------------
//  Channel | Direction | Contents
//  s_      | in        | tuser: func; tdata: data_byte, elapsed
//  m_      | out       | tuser: event_kind; tdata: seq_byte and decoded fields
//  cfg_    | in        | flush_threshold write
//
// A byte or tick is taken when the event queue is empty and the replay unit
// is idle. Each emitted item goes through a registered buffer read, a load
// state and an output state that waits for m_tready. Reset is synchronous
// and active low; the input stalls while an event is replayed.
`default_nettype none

module terminal_input_sequence_parser_core #(
    parameter int MAX_SEQ = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // data_byte[7:0], elapsed[23:8]
    input  wire logic [7:0]  s_tuser,   // func[0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // seq_byte, mouse_button, mouse_motion, mod_shift,
                                        // mod_meta, mod_control, pos_x, pos_y, shape_code
    output logic             m_tlast,
    output logic [7:0]       m_tuser    // event_kind[2:0]
);
    import tisp_pkg::*;

    localparam int SEQ_LIMIT = (MAX_SEQ < 64) ? MAX_SEQ : 64;
    localparam int AW = $clog2(SEQ_LIMIT);

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;
    logic          ev_push;
    ev_desc_t      ev;
    logic          q_pop;
    logic          back_idle;
    ev_desc_t      q_reg [2];
    logic          wp_reg, rp_reg;
    logic [1:0]    cnt_reg;
    logic          in_fire;

    assign s_tready = (cnt_reg == 2'd0) && back_idle;
    assign in_fire  = s_tvalid && s_tready;

    tisp_front #(.SEQ_LIMIT(SEQ_LIMIT)) u_front (
        .clk(aclk), .rstn(aresetn), .cfg_we(cfg_wr_en), .cfg_data(cfg_wr_data),
        .in_fire(in_fire), .func(s_tuser[0]), .data_byte(s_tdata[7:0]),
        .elapsed(s_tdata[23:8]), .ram_we(ram_we), .ram_waddr(ram_waddr),
        .ram_wdata(ram_wdata), .ev_push(ev_push), .ev(ev)
    );

    tisp_ram #(.WIDTH(8), .DEPTH(SEQ_LIMIT)) u_buf (
        .clk(aclk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
        .raddr(ram_raddr), .rdata(ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (ev_push) begin
                wp_reg <= !wp_reg;
            end
            if (q_pop) begin
                rp_reg <= !rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, ev_push} - {1'b0, q_pop};
        end
        if (ev_push) begin
            q_reg[wp_reg] <= ev;
        end
    end

    tisp_back #(.SEQ_LIMIT(SEQ_LIMIT)) u_back (
        .clk(aclk), .rstn(aresetn), .q_valid(cnt_reg != 2'd0), .q_data(q_reg[rp_reg]),
        .q_pop(q_pop), .idle(back_idle), .ram_raddr(ram_raddr), .ram_rdata(ram_rdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .m_tuser(m_tuser)
    );
endmodule

`default_nettype wire

>>> bench/tb_terminal_input_sequence_parser_core.sv
// ----------------------------------------------------------------------------
// Terminal input sequence parser testbench
// Drives bytes and time ticks through the input stream and checks each output
// item against an in-bench parser model, over several flush thresholds, with
// random idling on both streams.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_terminal_input_sequence_parser_core;
    import tisp_pkg::*;

    typedef struct packed {
        logic [7:0]  sb;
        logic        lst;
        logic [2:0]  kind;
        logic [2:0]  btn;
        logic [1:0]  motion;
        logic        shift;
        logic        meta;
        logic        ctrl;
        logic [15:0] x;
        logic [15:0] y;
        logic [8:0]  shape;
    } term_event_t;

    typedef struct {
        logic        func;
        logic [7:0]  data;
        logic [15:0] elapsed;
        logic        known;
        logic [7:0]  known_byte;
        logic [2:0]  known_kind;
    } term_input_t;

    typedef enum {P_WAIT, P_DROP, P_CHAR, P_SPECIAL, P_MOUSE, P_CURSOR, P_SHAPE} parse_res_t;

    localparam int SEQ_CAP = 64;
    localparam int CYCLE_LIMIT = 2000000;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic [7:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        m_tlast;
    logic [7:0]  m_tuser;

    terminal_input_sequence_parser_core u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser)
    );

    string key_from [REMAP_COUNT] = '{
        "\015", "\010", "\033OA", "\033OB", "\033OC", "\033OD", "\033OH", "\033OF",
        "\033[[A", "\033[[B", "\033[[C", "\033[[D", "\033[[E",
        "\033[11~", "\033[12~", "\033[13~", "\033[14~",
        "\033Ot", "\033Ou", "\033Ov", "\033Ol", "\033Ow", "\033Ox",
        "\033[M", "\033[N", "\033[O", "\033[P", "\033[Q", "\033[R",
        "\033[S", "\033[T", "\033[U", "\033[V", "\033[W", "\033[X"};
    string key_to [REMAP_COUNT] = '{
        "\012", "\177", "\033[A", "\033[B", "\033[C", "\033[D", "\033[H", "\033[F",
        "\033OP", "\033OQ", "\033OR", "\033OS", "\033[15~",
        "\033OP", "\033OQ", "\033OR", "\033OS",
        "\033[15~", "\033[17~", "\033[18~", "\033[19~", "\033[20~", "\033[21~",
        "\033OP", "\033OQ", "\033OR", "\033OS", "\033[15~", "\033[17~",
        "\033[18~", "\033[19~", "\033[20~", "\033[21~", "\033[23~", "\033[24~"};

    logic [7:0]  pend_buf [SEQ_CAP];
    int          pend_len;
    int          idle_acc;
    int          flush_thr;
    term_event_t event_q [$];
    term_input_t stim_q [$];
    int          errors = 0;
    int          cycles = 0;
    bit          calm;
    int          stall_left = 0;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_terminal_input_sequence_parser_core NOT OK");
            $finish;
        end
    end

    function automatic void push_bytes(term_event_t tmpl, logic [7:0] bytes [$]);
        term_event_t ev;
        for (int k = 0; k < bytes.size(); k++) begin
            ev = tmpl;
            ev.sb = bytes[k];
            ev.lst = (k == bytes.size() - 1);
            event_q.insert(event_q.size(), ev);
        end
    endfunction

    function automatic void push_pending(term_event_t tmpl);
        logic [7:0] bytes [$];
        for (int k = 0; k < pend_len; k++) bytes.insert(bytes.size(), pend_buf[k]);
        push_bytes(tmpl, bytes);
    endfunction

    function automatic void push_special();
        term_event_t tmpl;
        logic [7:0] bytes [$];
        bit hit;
        tmpl = '0;
        tmpl.kind = KIND_SPECIAL;
        for (int t = 0; t < REMAP_COUNT; t++) begin
            if (key_from[t].len() == pend_len) begin
                hit = 1'b1;
                for (int k = 0; k < pend_len; k++)
                    if (key_from[t][k] != pend_buf[k]) hit = 1'b0;
                if (hit) begin
                    for (int k = 0; k < key_to[t].len(); k++)
                        bytes.insert(bytes.size(), key_to[t][k]);
                    push_bytes(tmpl, bytes);
                    return;
                end
            end
        end
        push_pending(tmpl);
    endfunction

    function automatic parse_res_t scan_utf8();
        int ones;
        int need;
        logic [31:0] cp;
        ones = 0;
        while (ones < 8 && pend_buf[0][7 - ones]) ones++;
        if (ones == 1 || ones >= 5) return P_DROP;
        cp = pend_buf[0] & (8'h7F >> ones);
        for (int i = 1; i < ones; i++) begin
            if (i >= pend_len) return P_WAIT;
            if (pend_buf[i][7:6] != 2'b10) return P_DROP;
            cp = (cp << 6) | pend_buf[i][5:0];
        end
        if (cp <= 32'h7F) need = 0;
        else if (cp <= 32'h7FF) need = 1;
        else if (cp <= 32'hFFFF) need = 2;
        else if (cp <= 32'h10FFFF) need = 3;
        else return P_DROP;
        if (need != (ones == 0 ? 0 : ones - 1)) return P_DROP;
        return P_CHAR;
    endfunction

    function automatic bit string_closed();
        int i;
        i = 2;
        forever begin
            if (i >= pend_len) return 1'b0;
            if (pend_buf[i++] != C_ESC) continue;
            if (i >= pend_len) return 1'b0;
            if (pend_buf[i++] != C_BSL) continue;
            return 1'b1;
        end
    endfunction

    function automatic parse_res_t scan_csi(ref term_event_t ev);
        int i;
        int acc;
        int cnt;
        int store [3];
        logic [7:0] c;
        i = 2;
        acc = 0;
        cnt = 0;
        store = '{0, 0, 0};
        forever begin
            if (i >= pend_len) return P_WAIT;
            c = pend_buf[i++];
            if (c == "<") continue;
            if (c >= "0" && c <= "9") begin
                acc = acc * 10 + (c - "0");
                if (acc > 65535) acc = 65535;
                continue;
            end
            if (c == ";" || (c >= "@" && c <= "~" && c != "[")) begin
                if (cnt < 3) store[cnt] = acc;
                if (cnt < 7) cnt++;
                acc = 0;
                if (c == ";") continue;
                if (c == "M" || c == "m") begin
                    if (cnt != 3) return P_SPECIAL;
                    ev.btn = store[0][1:0] + (store[0][6] ? 3'd4 : 3'd0);
                    ev.motion = store[0][5] ? 2'd2 : (c == "M" ? 2'd1 : 2'd0);
                    ev.shift = store[0][2];
                    ev.meta = store[0][3];
                    ev.ctrl = store[0][4];
                    ev.x = store[1][15:0];
                    ev.y = store[2][15:0];
                    return P_MOUSE;
                end
                if (c == "R") begin
                    if (cnt != 2) return P_SPECIAL;
                    ev.y = store[0][15:0];
                    ev.x = store[1][15:0];
                    return P_CURSOR;
                end
                return P_SPECIAL;
            end
            if (c == C_ESC) return P_SPECIAL;
        end
    endfunction

    function automatic parse_res_t classify_pending(ref term_event_t ev);
        if (pend_buf[0] != C_ESC) begin
            if (pend_buf[0] < 8'd32 || pend_buf[0] == 8'd127) return P_SPECIAL;
            return scan_utf8();
        end
        if (pend_len < 2) return P_WAIT;
        case (pend_buf[1])
            "P": begin
                if (!string_closed()) return P_WAIT;
                if (pend_len == 10 && pend_buf[2] == "1" && pend_buf[3] == "$"
                        && pend_buf[4] == "r") begin
                    ev.shape = {1'b0, pend_buf[5]} - 9'd48;
                    return P_SHAPE;
                end
                return P_SPECIAL;
            end
            "[": return scan_csi(ev);
            "]": return string_closed() ? P_SPECIAL : P_WAIT;
            " ", "#", "%", "(", ")", "*", "+", "O", "N":
                return pend_len < 3 ? P_WAIT : P_SPECIAL;
            default: return P_SPECIAL;
        endcase
    endfunction

    function automatic void predict_item(term_input_t it);
        term_event_t ev;
        parse_res_t res;
        if (it.func) begin
            idle_acc += it.elapsed;
            if (idle_acc > 65535) idle_acc = 65535;
            if (idle_acc < flush_thr) return;
            idle_acc = 0;
            if (pend_len != 0) push_special();
            pend_len = 0;
            return;
        end
        if (pend_len >= SEQ_CAP) pend_len = 0;
        pend_buf[pend_len++] = it.data;
        idle_acc = 0;
        ev = '0;
        res = classify_pending(ev);
        case (res)
            P_WAIT: begin
                if (pend_len >= SEQ_CAP) pend_len = 0;
                return;
            end
            P_DROP: ;
            P_SPECIAL: push_special();
            P_CHAR: begin ev.kind = KIND_CHAR; push_pending(ev); end
            P_MOUSE: begin ev.kind = KIND_MOUSE; push_pending(ev); end
            P_CURSOR: begin ev.kind = KIND_CURSOR; push_pending(ev); end
            default: begin ev.kind = KIND_SHAPE; push_pending(ev); end
        endcase
        pend_len = 0;
    endfunction

    // Output side: random stall bursts, then checks against the oldest expectation.
    always @(posedge aclk) begin
        term_event_t got;
        term_event_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[7:0], m_tlast, m_tuser[2:0], m_tdata[10:8], m_tdata[12:11],
                   m_tdata[13], m_tdata[14], m_tdata[15], m_tdata[31:16], m_tdata[47:32],
                   m_tdata[56:48]};
            if (event_q.size() == 0) begin
                $display("%0t: unexpected item %p", $realtime, got);
                errors++;
            end else begin
                want = event_q.pop_front();
                if (got.sb !== want.sb || got.lst !== want.lst || got.kind !== want.kind
                        || got.btn !== want.btn || got.motion !== want.motion
                        || got.shift !== want.shift || got.meta !== want.meta
                        || got.ctrl !== want.ctrl || got.x !== want.x || got.y !== want.y
                        || got.shape !== want.shape) begin
                    $display("%0t: expected %p got %p", $realtime, want, got);
                    errors++;
                end
            end
        end
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 11);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_item(term_input_t it);
        s_tvalid <= 1'b1;
        s_tuser <= {7'd0, it.func};
        s_tdata <= {it.elapsed, it.data};
        do @(posedge aclk); while (!s_tready);
        if (it.known) begin
            predict_item(it);
            void'(event_q.pop_back());
            event_q.insert(event_q.size(), {it.known_byte, 1'b1, it.known_kind, 49'd0});
        end else begin
            predict_item(it);
        end
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    endtask

    task automatic drain_and_set(logic [15:0] thr);
        s_tvalid <= 1'b0;
        while (event_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= thr;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        flush_thr = thr;
    endtask

    function automatic void add_byte(logic [7:0] b);
        stim_q.insert(stim_q.size(), '{1'b0, b, 16'($urandom), 1'b0, 8'd0, 3'd0});
    endfunction

    function automatic void add_str(string s);
        for (int k = 0; k < s.len(); k++) add_byte(s[k]);
    endfunction

    function automatic void add_tick(logic [15:0] e);
        stim_q.insert(stim_q.size(), '{1'b1, 8'($urandom), e, 1'b0, 8'd0, 3'd0});
    endfunction

    function automatic string rand_body(int n);
        string s;
        s = "";
        for (int k = 0; k < n; k++)
            s = {s, string'(8'($urandom_range(0, 19) == 0 ? $urandom : $urandom_range(32, 126)))};
        return s;
    endfunction

    function automatic void gen_sequence();
        int pick;
        logic [20:0] cp;
        pick = $urandom_range(0, 15);
        case (pick)
            0: add_byte($urandom_range(32, 126));
            1: begin
                cp = $urandom_range(0, 2) == 0 ? 21'($urandom) : 21'($urandom_range(128, 2047));
                if (cp < 2048) begin
                    add_byte({3'b110, cp[10:6]}); add_byte({2'b10, cp[5:0]});
                end else if (cp < 65536) begin
                    add_byte({4'b1110, cp[15:12]}); add_byte({2'b10, cp[11:6]});
                    add_byte({2'b10, cp[5:0]});
                end else begin
                    add_byte({5'b11110, cp[20:18]}); add_byte({2'b10, cp[17:12]});
                    add_byte({2'b10, cp[11:6]}); add_byte({2'b10, cp[5:0]});
                end
            end
            2: add_byte($urandom_range(0, 31));
            3: add_str(key_from[$urandom_range(0, REMAP_COUNT - 1)]);
            4: add_str($sformatf("\033[<%0d;%0d;%0d%s", $urandom_range(0, 127),
                   $urandom_range(0, 3) == 0 ? $urandom_range(0, 99999) : $urandom_range(1, 300),
                   $urandom_range(1, 200), $urandom_range(0, 1) ? "M" : "m"));
            5: add_str($sformatf("\033[%0d;%0dR", $urandom_range(0, 70000),
                   $urandom_range(1, 999)));
            6: add_str($sformatf("\033P1$r%s q\033\\", string'(8'($urandom))));
            7: add_str({"\033]", rand_body($urandom_range(0, 12)), "\033\\"});
            8: add_str({"\033P", rand_body($urandom_range(0, 8)), "\033\\"});
            9: add_str({"\033", string'(8'($urandom_range(32, 126))),
                   string'(8'($urandom_range(32, 126)))});
            10: add_str($sformatf("\033[%0d;%0d;%0d;%0d%s", $urandom_range(0, 9),
                    $urandom_range(0, 9), $urandom_range(0, 9), $urandom_range(0, 9),
                    string'(8'($urandom_range(64, 126)))));
            11: add_tick($urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 60)));
            12: add_str({"\033]", rand_body($urandom_range(0, 1) ? 60 : 70)});
            13: add_str({"\033[", rand_body($urandom_range(1, 6))});
            14: add_byte($urandom);
            default: begin
                add_str({"\033", string'(8'($urandom_range(0, 1) ? "O" : "["))});
                add_tick($urandom_range(0, 1) ? 16'd65535 : 16'($urandom_range(1, 80)));
            end
        endcase
    endfunction

    term_input_t directed [] = '{
        '{1'b0, "A", 16'h0000, 1'b1, "A", KIND_CHAR},
        '{1'b0, 8'h0D, 16'hFFFF, 1'b1, 8'h0A, KIND_SPECIAL},
        '{1'b0, 8'h08, 16'h0000, 1'b1, 8'h7F, KIND_SPECIAL},
        '{1'b0, 8'h7F, 16'h0000, 1'b1, 8'h7F, KIND_SPECIAL},
        '{1'b0, 8'h00, 16'h0000, 1'b1, 8'h00, KIND_SPECIAL},
        '{1'b0, 8'h80, 16'h0000, 1'b0, 8'h00, KIND_CHAR},
        '{1'b0, 8'hFF, 16'h0000, 1'b0, 8'h00, KIND_CHAR},
        '{1'b0, 8'h1B, 16'h0000, 1'b0, 8'h00, KIND_CHAR},
        '{1'b1, 8'hFF, 16'hFFFF, 1'b1, 8'h1B, KIND_SPECIAL},
        '{1'b1, 8'h00, 16'hFFFF, 1'b0, 8'h00, KIND_CHAR},
        '{1'b0, 8'h1B, 16'h0000, 1'b0, 8'h00, KIND_CHAR},
        '{1'b0, "O", 16'h0000, 1'b0, 8'h00, KIND_CHAR},
        '{1'b0, "A", 16'h0000, 1'b0, 8'h00, KIND_CHAR},
        '{1'b0, 8'hE2, 16'h0000, 1'b0, 8'h00, KIND_CHAR},
        '{1'b0, 8'h82, 16'h0000, 1'b0, 8'h00, KIND_CHAR},
        '{1'b0, 8'hAC, 16'h0000, 1'b0, 8'h00, KIND_CHAR},
        '{1'b0, 8'hC0, 16'h0000, 1'b0, 8'h00, KIND_CHAR},
        '{1'b0, 8'h80, 16'h0000, 1'b0, 8'h00, KIND_CHAR},
        '{1'b0, 8'h1B, 16'h0000, 1'b0, 8'h00, KIND_CHAR},
        '{1'b0, "[", 16'h0000, 1'b0, 8'h00, KIND_CHAR},
        '{1'b0, "9", 16'h0000, 1'b0, 8'h00, KIND_CHAR},
        '{1'b0, "9", 16'h0000, 1'b0, 8'h00, KIND_CHAR},
        '{1'b0, "9", 16'h0000, 1'b0, 8'h00, KIND_CHAR},
        '{1'b0, "9", 16'h0000, 1'b0, 8'h00, KIND_CHAR},
        '{1'b0, "9", 16'h0000, 1'b0, 8'h00, KIND_CHAR},
        '{1'b0, "R", 16'h0000, 1'b0, 8'h00, KIND_CHAR}
    };

    initial begin
        logic [15:0] phase_thr [4];
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = 16'd0;
        s_tvalid = 1'b0;
        s_tdata = 24'd0;
        s_tuser = 8'd0;
        calm = 1'b0;
        pend_len = 0;
        idle_acc = 0;
        flush_thr = 50;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i]) send_item(directed[i]);

        phase_thr = '{16'd1, 16'd65535, 16'($urandom_range(2, 300)), 16'd50};
        foreach (phase_thr[p]) begin
            drain_and_set(phase_thr[p]);
            if (p == 3) calm = 1'b1;
            stim_q.delete();
            while (stim_q.size() < 72) gen_sequence();
            add_tick(16'hFFFF);
            while (stim_q.size() != 0) send_item(stim_q.pop_front());
        end
        s_tvalid <= 1'b0;

        while (event_q.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (errors == 0) begin
            $display("tb_terminal_input_sequence_parser_core OK");
        end else begin
            $display("tb_terminal_input_sequence_parser_core NOT OK");
        end
        $finish;
    end

endmodule
